@@ rtl/lfust_pkg.sv @@
// ----------------------------------------------------------------------------
// lfust_pkg
// Shared constants, codes and control types for the lfu slot table.
// ----------------------------------------------------------------------------
package lfust_pkg;

	localparam int SLOTS_DEF   = 16;
	localparam int ID_BITS_DEF = 8;
	localparam int CFG_W       = 5;
	localparam int VOTE_W      = 16;
	localparam int ACT_W       = 2;

	localparam logic [VOTE_W-1:0] VOTE_MAX   = 16'hFFFF;
	localparam logic [VOTE_W-1:0] VOTE_ONE   = 16'd1;
	localparam logic [CFG_W-1:0]  ACTIVE_RST = 5'd16;

	typedef enum logic [ACT_W-1:0] {
		ACT_HIT     = 2'd0,
		ACT_INSERT  = 2'd1,
		ACT_REPLACE = 2'd2
	} action_t;

	// control from the sequencer to the compare unit
	typedef struct packed {
		logic start;
		logic chk;
	} scan_ctl_t;

	// what the scan found
	typedef struct packed {
		logic hit;
		logic free;
		logic vic;
	} scan_flags_t;

endpackage

@@ rtl/lfust_mem.sv @@
// ----------------------------------------------------------------------------
// lfust_mem
// Slot entry memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lfust_mem #(
	parameter int SLOTS  = 16,
	parameter int WORD_W = 28,
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [IDX_W-1:0]  waddr,
	input  logic [WORD_W-1:0] wdata,
	input  logic [IDX_W-1:0]  raddr,
	output logic [WORD_W-1:0] rdata
);

	logic [WORD_W-1:0] mem [SLOTS];
	logic [WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/lfust_scan.sv @@
// ----------------------------------------------------------------------------
// lfust_scan
// Compare unit: looks at one entry per cycle and keeps the first match,
// the lowest free slot and the least-count oldest entry seen so far.
// ----------------------------------------------------------------------------
module lfust_scan #(
	parameter int SLOTS   = 16,
	parameter int ID_BITS = 8,
	localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1,
	localparam int CNT_W  = $clog2(SLOTS + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lfust_pkg::scan_ctl_t      ctl,
	input  logic [IDX_W-1:0]          idx,
	input  logic                      entry_vld,
	input  logic [ID_BITS-1:0]        ident,
	input  logic [lfust_pkg::VOTE_W-1:0] votes,
	input  logic [CNT_W-1:0]          rank,
	input  logic [ID_BITS-1:0]        cand,
	input  logic                      pend_vld,
	input  logic [CNT_W-1:0]          pend_rank,
	output logic [CNT_W-1:0]          eff_rank,
	output lfust_pkg::scan_flags_t    flags,
	output logic [IDX_W-1:0]          hit_idx,
	output logic [lfust_pkg::VOTE_W-1:0] hit_votes,
	output logic [CNT_W-1:0]          hit_rank,
	output logic [IDX_W-1:0]          free_idx,
	output logic [IDX_W-1:0]          vic_idx,
	output logic [ID_BITS-1:0]        vic_ident,
	output logic [CNT_W-1:0]          vic_rank
);
	import lfust_pkg::*;

	scan_flags_t       flags_q;
	logic [IDX_W-1:0]  hit_idx_q;
	logic [VOTE_W-1:0] hit_votes_q;
	logic [CNT_W-1:0]  hit_rank_q;
	logic [IDX_W-1:0]  free_idx_q;
	logic [IDX_W-1:0]  vic_idx_q;
	logic [ID_BITS-1:0] vic_ident_q;
	logic [VOTE_W-1:0] vic_votes_q;
	logic [CNT_W-1:0]  vic_rank_q;
	logic              is_hit;
	logic              is_free;
	logic              is_vic;

	// ranks above the last evicted rank close the gap as they are read
	assign eff_rank = (pend_vld && (rank > pend_rank)) ? rank - CNT_W'(1) : rank;

	assign is_hit  = ctl.chk && entry_vld && !flags_q.hit && (ident == cand);
	assign is_free = ctl.chk && !entry_vld && !flags_q.free;
	assign is_vic  = ctl.chk && entry_vld &&
		(!flags_q.vic || (votes < vic_votes_q) ||
		 ((votes == vic_votes_q) && (eff_rank < vic_rank_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (ctl.start) begin
			flags_q <= '0;
		end else begin
			flags_q.hit  <= flags_q.hit  | is_hit;
			flags_q.free <= flags_q.free | is_free;
			flags_q.vic  <= flags_q.vic  | is_vic;
		end
	end

	always_ff @(posedge clk) begin
		if (is_hit) begin
			hit_idx_q   <= idx;
			hit_votes_q <= votes;
			hit_rank_q  <= eff_rank;
		end
		if (is_free) begin
			free_idx_q <= idx;
		end
		if (is_vic) begin
			vic_idx_q   <= idx;
			vic_ident_q <= ident;
			vic_votes_q <= votes;
			vic_rank_q  <= eff_rank;
		end
	end

	assign flags     = flags_q;
	assign hit_idx   = hit_idx_q;
	assign hit_votes = hit_votes_q;
	assign hit_rank  = hit_rank_q;
	assign free_idx  = free_idx_q;
	assign vic_idx   = vic_idx_q;
	assign vic_ident = vic_ident_q;
	assign vic_rank  = vic_rank_q;

endmodule

@@ rtl/lfu_slot_table_fifo_tiebreak_core.sv @@
// ----------------------------------------------------------------------------
// lfu_slot_table_fifo_tiebreak_core
// Least-frequently-used slot table with oldest-first tie break.
//
// Input channel (in_valid/in_ready) takes one candidate_id word per vote.
// Output channel (out_valid/out_ready) returns one word per vote: action,
// slot_index, new_count and evicted_id.
// Config channel (cfg_valid/cfg_ready) writes active_slots; always ready.
// Each vote is a scan of every slot through the single entry memory read port
// and compare unit, a drain step for the last read and a commit step. in_ready
// is high only while the sequencer is idle, so a new vote is taken only after
// the previous one has committed.
// The result sits in an output register; a stalled receiver holds the next
// vote in the commit cycle until the register frees up.
// Reset empties the table (valid bits cleared) and sets active_slots to 16;
// the entry memory needs no clearing.
// ----------------------------------------------------------------------------
module lfu_slot_table_fifo_tiebreak_core #(
	parameter int SLOTS   = lfust_pkg::SLOTS_DEF,
	parameter int ID_BITS = lfust_pkg::ID_BITS_DEF,
	localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [lfust_pkg::CFG_W-1:0] cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [ID_BITS-1:0]          candidate_id,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [lfust_pkg::ACT_W-1:0] action,
	output logic [IDX_W-1:0]            slot_index,
	output logic [lfust_pkg::VOTE_W-1:0] new_count,
	output logic [ID_BITS-1:0]          evicted_id
);
	import lfust_pkg::*;

	localparam int CNT_W  = $clog2(SLOTS + 1);
	localparam int WORD_W = ID_BITS + VOTE_W + CNT_W;
	localparam int LIM_W  = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_DRAIN  = 4'b0100,
		S_COMMIT = 4'b1000
	} state_t;

	state_t             state_q;
	logic [IDX_W-1:0]   addr_q;
	logic               chk_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [ID_BITS-1:0] cand_q;
	logic [CFG_W-1:0]   active_q;
	logic [SLOTS-1:0]   vld_q;
	logic [CNT_W-1:0]   occ_q;
	logic               pend_vld_q;
	logic [CNT_W-1:0]   pend_rank_q;

	logic               out_valid_q;
	action_t            act_q;
	logic [IDX_W-1:0]   slot_q;
	logic [VOTE_W-1:0]  count_q;
	logic [ID_BITS-1:0] evict_q;

	logic               in_fire;
	logic               commit_fire;
	scan_ctl_t          ctl;
	scan_flags_t        flags;
	logic [WORD_W-1:0]  rd_word;
	logic [ID_BITS-1:0] rd_ident;
	logic [VOTE_W-1:0]  rd_votes;
	logic [CNT_W-1:0]   rd_rank;
	logic               entry_vld;
	logic [CNT_W-1:0]   eff_rank;
	logic [IDX_W-1:0]   hit_idx;
	logic [VOTE_W-1:0]  hit_votes;
	logic [CNT_W-1:0]   hit_rank;
	logic [IDX_W-1:0]   free_idx;
	logic [IDX_W-1:0]   vic_idx;
	logic [ID_BITS-1:0] vic_ident;
	logic [CNT_W-1:0]   vic_rank;

	logic [LIM_W-1:0]   lim;
	logic               can_insert;
	action_t            act_d;
	logic [IDX_W-1:0]   slot_d;
	logic [VOTE_W-1:0]  count_d;
	logic [ID_BITS-1:0] evict_d;
	logic [CNT_W-1:0]   rank_d;

	logic               mem_we;
	logic [IDX_W-1:0]   mem_waddr;
	logic [WORD_W-1:0]  mem_wdata;

	assign cfg_ready   = 1'b1;
	assign in_ready    = (state_q == S_IDLE);
	assign in_fire     = in_valid && in_ready;
	assign commit_fire = (state_q == S_COMMIT) && (!out_valid_q || out_ready);

	assign ctl = '{start: in_fire, chk: chk_s1};

	assign {rd_ident, rd_votes, rd_rank} = rd_word;
	assign entry_vld = vld_q[idx_s1];

	lfust_mem #(
		.SLOTS  (SLOTS),
		.WORD_W (WORD_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (addr_q),
		.rdata (rd_word)
	);

	lfust_scan #(
		.SLOTS   (SLOTS),
		.ID_BITS (ID_BITS)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.idx       (idx_s1),
		.entry_vld (entry_vld),
		.ident     (rd_ident),
		.votes     (rd_votes),
		.rank      (rd_rank),
		.cand      (cand_q),
		.pend_vld  (pend_vld_q),
		.pend_rank (pend_rank_q),
		.eff_rank  (eff_rank),
		.flags     (flags),
		.hit_idx   (hit_idx),
		.hit_votes (hit_votes),
		.hit_rank  (hit_rank),
		.free_idx  (free_idx),
		.vic_idx   (vic_idx),
		.vic_ident (vic_ident),
		.vic_rank  (vic_rank)
	);

	// active_slots clamped to 1..SLOTS
	always_comb begin
		if (active_q == '0) begin
			lim = LIM_W'(1);
		end else if (LIM_W'(active_q) > LIM_W'(SLOTS)) begin
			lim = LIM_W'(SLOTS);
		end else begin
			lim = LIM_W'(active_q);
		end
	end

	assign can_insert = flags.free && (LIM_W'(occ_q) < lim);

	always_comb begin
		act_d   = ACT_REPLACE;
		slot_d  = vic_idx;
		count_d = VOTE_ONE;
		evict_d = vic_ident;
		// a replacing entry is stored one rank high; the pending gap fix brings it down
		rank_d  = occ_q;
		if (flags.hit) begin
			act_d   = ACT_HIT;
			slot_d  = hit_idx;
			count_d = (hit_votes == VOTE_MAX) ? hit_votes : hit_votes + VOTE_ONE;
			evict_d = '0;
			rank_d  = hit_rank;
		end else if (can_insert) begin
			act_d   = ACT_INSERT;
			slot_d  = free_idx;
			evict_d = '0;
		end
	end

	// write port: commit word, else rank write-back of the scanned entry
	always_comb begin
		if (commit_fire) begin
			mem_we    = 1'b1;
			mem_waddr = slot_d;
			mem_wdata = {cand_q, count_d, rank_d};
		end else begin
			mem_we    = chk_s1 && entry_vld;
			mem_waddr = idx_s1;
			mem_wdata = {rd_ident, rd_votes, eff_rank};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			chk_s1  <= 1'b0;
		end else begin
			chk_s1 <= (state_q == S_SCAN);
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (addr_q == IDX_W'(SLOTS - 1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					if (commit_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= addr_q;
		if (in_fire) begin
			cand_q <= candidate_id;
			addr_q <= '0;
		end else if (state_q == S_SCAN) begin
			addr_q <= addr_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RST;
		end else if (cfg_valid && cfg_ready) begin
			active_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			occ_q       <= '0;
			pend_vld_q  <= 1'b0;
			pend_rank_q <= '0;
		end else if (commit_fire) begin
			pend_vld_q <= (act_d == ACT_REPLACE);
			if (act_d == ACT_REPLACE) begin
				pend_rank_q <= vic_rank;
			end
			if (act_d == ACT_INSERT) begin
				vld_q[free_idx] <= 1'b1;
				occ_q           <= occ_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit_fire) begin
			act_q   <= act_d;
			slot_q  <= slot_d;
			count_q <= count_d;
			evict_q <= evict_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign action     = act_q;
	assign slot_index = slot_q;
	assign new_count  = count_q;
	assign evicted_id = evict_q;

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_start_scan: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == S_SCAN) && (addr_q == '0))
		else $error("accepted word did not start a scan at slot zero");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CNT_W'(SLOTS))
		else $error("occupancy above slot count");

	a_insert_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(commit_fire && (act_d == ACT_INSERT)) |=> (occ_q == $past(occ_q) + CNT_W'(1)))
		else $error("insert did not grow occupancy");

	a_victim_found: assert property (@(posedge clk) disable iff (!arst_n)
		(commit_fire && (act_d == ACT_REPLACE)) |-> flags.vic)
		else $error("replace without a victim");

endmodule

@@ test/lfu_slot_table_checker.sv @@
// ----------------------------------------------------------------------------
// lfu_slot_table_checker
// Watches the config, vote and result channels of the lfu slot table. Keeps
// its own copy of the table (ids, vote counts, insertion ranks, active limit),
// works out the result of every accepted vote and checks each returned word
// field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module lfu_slot_table_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [lfust_pkg::CFG_W-1:0]  cfg_data,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic [lfust_pkg::ID_BITS_DEF-1:0] candidate_id,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic [lfust_pkg::ACT_W-1:0]  action,
	input  logic [$clog2(lfust_pkg::SLOTS_DEF)-1:0] slot_index,
	input  logic [lfust_pkg::VOTE_W-1:0] new_count,
	input  logic [lfust_pkg::ID_BITS_DEF-1:0] evicted_id,
	output int                           mismatches,
	output int                           results_due
);
	import lfust_pkg::*;

	localparam int SLOTS  = SLOTS_DEF;
	localparam int ID_W   = ID_BITS_DEF;
	localparam int SLOT_W = $clog2(SLOTS_DEF);

	typedef struct packed {
		action_t             act;
		logic [SLOT_W-1:0]   slot;
		logic [VOTE_W-1:0]   votes;
		logic [ID_W-1:0]     evicted;
	} vote_res_t;

	logic              in_use [SLOTS];
	logic [ID_W-1:0]   tag    [SLOTS];
	logic [VOTE_W-1:0] tally  [SLOTS];
	logic [SLOT_W-1:0] age    [SLOTS];
	logic [CFG_W-1:0]  active_lim;

	vote_res_t due_results [$];
	int errs;

	function automatic vote_res_t tally_vote(input logic [ID_W-1:0] id);
		vote_res_t res;
		int i, occ, hit_at, free_at, victim, lim;
		logic [SLOT_W-1:0] gone_rank;
		res = '0;
		occ = 0;
		hit_at = -1;
		free_at = -1;
		victim = -1;
		lim = int'(active_lim);
		if (lim < 1) lim = 1;
		if (lim > SLOTS) lim = SLOTS;
		for (i = 0; i < SLOTS; i++) begin
			if (in_use[i]) begin
				occ++;
				if (hit_at < 0 && tag[i] == id) hit_at = i;
				if (victim < 0 || tally[i] < tally[victim] ||
				    (tally[i] == tally[victim] && age[i] < age[victim]))
					victim = i;
			end else if (free_at < 0) begin
				free_at = i;
			end
		end
		if (hit_at >= 0) begin
			if (tally[hit_at] != VOTE_MAX) tally[hit_at]++;
			res.act = ACT_HIT;
			res.slot = SLOT_W'(hit_at);
			res.votes = tally[hit_at];
		end else if (occ < lim && free_at >= 0) begin
			in_use[free_at] = 1'b1;
			tag[free_at] = id;
			tally[free_at] = VOTE_ONE;
			age[free_at] = SLOT_W'(occ);
			res.act = ACT_INSERT;
			res.slot = SLOT_W'(free_at);
			res.votes = VOTE_ONE;
		end else begin
			// table is non-empty here, so a victim always exists
			gone_rank = age[victim];
			for (i = 0; i < SLOTS; i++)
				if (in_use[i] && age[i] > gone_rank) age[i]--;
			res.evicted = tag[victim];
			tag[victim] = id;
			tally[victim] = VOTE_ONE;
			age[victim] = SLOT_W'(occ - 1);
			res.act = ACT_REPLACE;
			res.slot = SLOT_W'(victim);
			res.votes = VOTE_ONE;
		end
		return res;
	endfunction

	function automatic void check_field(input string what, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
			errs++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		vote_res_t want;
		int i;
		if (!arst_n) begin
			for (i = 0; i < SLOTS; i++) in_use[i] = 1'b0;
			active_lim = ACTIVE_RST;
			due_results.delete();
			errs = 0;
			mismatches <= 0;
			results_due <= 0;
		end else begin
			if (cfg_valid && cfg_ready) active_lim = cfg_data;
			if (in_valid && in_ready) due_results = {due_results, tally_vote(candidate_id)};
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					$display("%0t: result word with none expected, got action %0d slot %0d",
						$time, action, slot_index);
					errs++;
				end else begin
					want = due_results.pop_front();
					check_field("action", 32'(want.act), 32'(action));
					check_field("slot_index", 32'(want.slot), 32'(slot_index));
					check_field("new_count", 32'(want.votes), 32'(new_count));
					check_field("evicted_id", 32'(want.evicted), 32'(evicted_id));
				end
			end
			mismatches <= errs;
			results_due <= due_results.size();
		end
	end

endmodule

@@ test/lfu_slot_table_fifo_tiebreak_core_tb.sv @@
// ----------------------------------------------------------------------------
// lfu_slot_table_fifo_tiebreak_core_tb
// Drives votes and active_slots writes into the lfu slot table: a directed
// run over inserts, hits, tie-broken replacements and out-of-range limits,
// then random rounds over many limits with bursty idling on both channels.
// The checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module lfu_slot_table_fifo_tiebreak_core_tb;
	import lfust_pkg::*;

	localparam int ID_W       = ID_BITS_DEF;
	localparam int SLOT_W     = $clog2(SLOTS_DEF);
	localparam int STALL_LIMIT = 2000;

	logic                clk;
	logic                arst_n       = 1'b0;
	logic                cfg_valid    = 1'b0;
	logic                cfg_ready;
	logic [CFG_W-1:0]    cfg_data     = '0;
	logic                in_valid     = 1'b0;
	logic                in_ready;
	logic [ID_W-1:0]     candidate_id = '0;
	logic                out_valid;
	logic                out_ready    = 1'b0;
	logic [ACT_W-1:0]    action;
	logic [SLOT_W-1:0]   slot_index;
	logic [VOTE_W-1:0]   new_count;
	logic [ID_W-1:0]     evicted_id;

	int mismatches;
	int results_due;
	int idle_cycles;
	int gap_pct = 0;
	bit stall_on = 1'b1;

	lfu_slot_table_fifo_tiebreak_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.candidate_id (candidate_id),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.action       (action),
		.slot_index   (slot_index),
		.new_count    (new_count),
		.evicted_id   (evicted_id)
	);

	lfu_slot_table_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.candidate_id (candidate_id),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.action       (action),
		.slot_index   (slot_index),
		.new_count    (new_count),
		.evicted_id   (evicted_id),
		.mismatches   (mismatches),
		.results_due  (results_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver side: ready drops in bursts while stalls are enabled
	initial begin
		forever begin
			@(posedge clk);
			if (stall_on && $urandom_range(0, 99) < 12) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((in_valid && in_ready) || (out_valid && out_ready) ||
		             (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("lfu_slot_table_fifo_tiebreak_core_tb: done, errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic cast_vote(input logic [ID_W-1:0] id);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		candidate_id <= id;
		do @(posedge clk); while (!in_ready);
	endtask

	// wait until every vote has its result word back
	task automatic settle();
		@(posedge clk);
		while (results_due != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_active_slots(input logic [CFG_W-1:0] lim);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= lim;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// votes drawn mostly from a small skewed id set so the table fills,
	// counts spread out and evictions with ties show up
	task automatic random_round(input int n, input logic [CFG_W-1:0] lim, input bit calm);
		logic [ID_W-1:0] pool [20];
		int eff, width, k;
		set_active_slots(lim);
		eff = (lim == 0) ? 1 : (lim > SLOTS_DEF) ? SLOTS_DEF : int'(lim);
		width = eff + $urandom_range(0, 4);
		for (k = 0; k < 20; k++) pool[k] = ID_W'($urandom_range(0, 255));
		gap_pct = calm ? 0 : $urandom_range(0, 40);
		stall_on = !calm && ($urandom_range(0, 3) != 0);
		for (k = 0; k < n; k++) begin
			if ($urandom_range(0, 99) < 80)
				cast_vote(pool[$urandom_range(0, $urandom_range(0, width - 1))]);
			else
				cast_vote(ID_W'($urandom_range(0, 255)));
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// three slots: fill, hit, then replace with oldest-first tie break
		set_active_slots(5'd3);
		cast_vote(8'h00);
		cast_vote(8'hFF);
		cast_vote(8'h00);
		cast_vote(8'hAA);
		cast_vote(8'h55);
		cast_vote(8'h55);
		cast_vote(8'hAA);
		cast_vote(8'h33);
		in_valid <= 1'b0;
		// zero limit acts as one, below occupancy: both votes replace
		set_active_slots(5'd0);
		cast_vote(8'hFF);
		cast_vote(8'h33);
		in_valid <= 1'b0;
		// limit above the table size: inserts into lowest free slots, then a hit
		set_active_slots(5'd31);
		cast_vote(8'h80);
		cast_vote(8'h01);
		cast_vote(8'h7F);
		cast_vote(8'hFE);
		cast_vote(8'h80);
		in_valid <= 1'b0;

		random_round(200, 5'd16, 1'b0);
		random_round(200, 5'd4, 1'b0);
		random_round(200, 5'd1, 1'b0);
		random_round(200, 5'd31, 1'b0);
		random_round(200, 5'd8, 1'b0);
		random_round(200, 5'd0, 1'b0);
		random_round(200, 5'd17, 1'b0);
		random_round(200, 5'($urandom_range(0, 31)), 1'b0);
		random_round(200, 5'($urandom_range(0, 31)), 1'b0);
		random_round(200, 5'd16, 1'b1);

		settle();
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("lfu_slot_table_fifo_tiebreak_core_tb: done, clean");
		else
			$display("lfu_slot_table_fifo_tiebreak_core_tb: done, errors");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/lfust_pkg.sv
rtl/lfust_mem.sv
rtl/lfust_scan.sv
rtl/lfu_slot_table_fifo_tiebreak_core.sv
test/lfu_slot_table_checker.sv
test/lfu_slot_table_fifo_tiebreak_core_tb.sv
